/* src/ils_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the indexed list store.
// No dependencies; every other file imports this package.
package ils_pkg;

  typedef logic [2:0]        op_t;
  typedef logic [1:0]        status_t;
  typedef logic [8:0]        pos_t;
  typedef logic [8:0]        ent_t;
  typedef logic signed [31:0] word_t;
  typedef logic signed [8:0]  hit_t;

  localparam op_t OP_APPEND = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_REMOVE = 3'd2;
  localparam op_t OP_GET    = 3'd3;
  localparam op_t OP_SET    = 3'd4;
  localparam op_t OP_SEARCH = 3'd5;
  localparam op_t OP_CLEAR  = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam hit_t HIT_NONE = '1;

endpackage

/* src/ils_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the list store.
// Depends on ils_pkg for the payload types.
interface ils_in_if import ils_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  pos_t  position;
  word_t word_in;

  modport source (output valid, op, position, word_in, input ready);
  modport sink   (input valid, op, position, word_in, output ready);
endinterface

interface ils_out_if import ils_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   word_out;
  hit_t    hit_index;
  ent_t    entries;

  modport source (output valid, status, word_out, hit_index, entries, input ready);
  modport sink   (input valid, status, word_out, hit_index, entries, output ready);
endinterface

/* src/indexed_list_store.sv */
`timescale 1ns / 1ps
// Indexed list store: ordered list of signed words in one synchronous RAM plus a count.
// Depends on ils_pkg and the channel interfaces in ils_if.sv.
//
//   channel  | dir | payload                               | transfer when
//   in_ch    | in  | op, position, word_in                 | valid & ready
//   out_ch   | out | status, word_out, hit_index, entries  | valid & ready
//
// One request at a time. Append, insert at the end, clear, the unused op code and rejects
// are done in the execute state before the result is emitted; in range, get, set and remove
// first read the entry at the position. Insert and remove move one word a cycle, fewer than
// CAPACITY words in all. Binary search runs probes that are each a RAM read and a compare,
// at most ceil(log2(count+1)) probes. Reset clears count and control only.
// A result waiting in the output register does not block the next transfer on in_ch.
module indexed_list_store import ils_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic clk,
  input  logic rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 9) ? CW : 9;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDPOS = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          sh_wr_v_r, sh_wr_v_nxt;
  logic          out_valid_r, out_valid_nxt;

  op_t           op_r, op_nxt;
  pos_t          pos_r, pos_nxt;
  word_t         w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, left_r, left_nxt;
  logic [AW-1:0] mid_r, mid_nxt, src_r, src_nxt, sh_dst_r, sh_dst_nxt;
  status_t       res_status_r, res_status_nxt;
  word_t         res_word_r, res_word_nxt;
  hit_t          res_hit_r, res_hit_nxt;
  status_t       out_status_r, out_status_nxt;
  word_t         out_word_r, out_word_nxt;
  hit_t          out_hit_r, out_hit_nxt;
  ent_t          out_ent_r, out_ent_nxt;

  logic [PW-1:0] pos_w, cnt_w;
  logic [CW-1:0] pos_c;
  logic [AW-1:0] pos_a, cnt_a;
  logic [CW:0]   mid_sum;
  logic          full, is_ins, emit_go;

  assign pos_w   = PW'(pos_r);
  assign cnt_w   = PW'(count_r);
  assign pos_c   = pos_w[CW-1:0];
  assign pos_a   = pos_w[AW-1:0];
  assign cnt_a   = count_r[AW-1:0];
  assign full    = (cnt_w == PW'(CAPACITY));
  assign is_ins  = (op_r == OP_INSERT);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW + 1)'(1);
  assign emit_go = !out_valid_r || out_ch.ready;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.word_out  = out_word_r;
  assign out_ch.hit_index = out_hit_r;
  assign out_ch.entries   = out_ent_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sh_wr_v_nxt    = sh_wr_v_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    w_nxt          = w_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    left_nxt       = left_r;
    mid_nxt        = mid_r;
    src_nxt        = src_r;
    sh_dst_nxt     = sh_dst_r;
    res_status_nxt = res_status_r;
    res_word_nxt   = res_word_r;
    res_hit_nxt    = res_hit_r;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_hit_nxt    = out_hit_r;
    out_ent_nxt    = out_ent_r;
    rd_en          = 1'b0;
    rd_addr        = pos_a;
    wr_en          = 1'b0;
    wr_addr        = pos_a;
    wr_data        = w_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_ch.op;
          pos_nxt        = in_ch.position;
          w_nxt          = in_ch.word_in;
          res_status_nxt = ST_OK;
          res_word_nxt   = '0;
          res_hit_nxt    = '0;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_EMIT;
        unique case (op_r)
          OP_APPEND: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = cnt_a;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_INSERT: begin
            priority if (pos_w > cnt_w) begin
              res_status_nxt = ST_RANGE;
            end else if (full) begin
              res_status_nxt = ST_FULL;
            end else if (pos_w == cnt_w) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              src_nxt     = cnt_a - AW'(1);
              left_nxt    = count_r - pos_c;
              sh_wr_v_nxt = 1'b0;
              state_nxt   = S_SHIFT;
            end
          end
          OP_REMOVE, OP_GET, OP_SET: begin
            if (pos_w >= cnt_w) begin
              res_status_nxt = ST_RANGE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_RDPOS;
            end
          end
          OP_SEARCH: begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = S_PROBE;
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_RDPOS: begin
        res_word_nxt = word_t'(rd_data_r);
        state_nxt    = S_EMIT;
        if (op_r == OP_SET) begin
          wr_en = 1'b1;
        end
        if (op_r == OP_REMOVE) begin
          if (pos_c == count_r - CW'(1)) begin
            count_nxt = count_r - CW'(1);
          end else begin
            src_nxt     = pos_a + AW'(1);
            left_nxt    = count_r - CW'(1) - pos_c;
            sh_wr_v_nxt = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sh_wr_v_r) begin
          wr_en   = 1'b1;
          wr_addr = sh_dst_r;
          wr_data = rd_data_r;
        end
        if (left_r != '0) begin
          rd_en       = 1'b1;
          rd_addr     = src_r;
          sh_dst_nxt  = is_ins ? src_r + AW'(1) : src_r - AW'(1);
          src_nxt     = is_ins ? src_r - AW'(1) : src_r + AW'(1);
          left_nxt    = left_r - CW'(1);
          sh_wr_v_nxt = 1'b1;
        end else begin
          sh_wr_v_nxt = 1'b0;
          if (!sh_wr_v_r) begin
            state_nxt = S_EMIT;
            if (is_ins) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid_sum[AW:1];
          mid_nxt   = mid_sum[AW:1];
          state_nxt = S_CMP;
        end else begin
          res_hit_nxt = HIT_NONE;
          state_nxt   = S_EMIT;
        end
      end
      S_CMP: begin
        priority if (rd_data_r == w_r) begin
          res_hit_nxt = hit_t'(PW'(mid_r));
          state_nxt   = S_EMIT;
        end else if ($signed(rd_data_r) < w_r) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = S_PROBE;
        end else begin
          hi_nxt    = CW'(mid_r);
          state_nxt = S_PROBE;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_word_nxt   = res_word_r;
          out_hit_nxt    = res_hit_r;
          out_ent_nxt    = cnt_w[8:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sh_wr_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sh_wr_v_r   <= sh_wr_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    w_r          <= w_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    left_r       <= left_nxt;
    mid_r        <= mid_nxt;
    src_r        <= src_nxt;
    sh_dst_r     <= sh_dst_nxt;
    res_status_r <= res_status_nxt;
    res_word_r   <= res_word_nxt;
    res_hit_r    <= res_hit_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_hit_r    <= out_hit_nxt;
    out_ent_r    <= out_ent_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= PW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)) ||
      (count_r == '0))
    else $error("entry count moved by more than one");

  a_shift_ports: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("shift reads and writes the same entry");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && emit_go && res_status_r == ST_FULL |-> full)
    else $error("full status reported below capacity");

  a_hit_only_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && res_hit_r != '0 |-> op_r == OP_SEARCH)
    else $error("hit index set by a request other than search");

endmodule

/* tb/tb_indexed_list_store.sv */
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_store: directed and random list requests,
// each result checked against an in-bench list predictor. Depends on ils_pkg, ils_if.sv
// and the indexed_list_store RTL.
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int      CAPACITY    = 256;
  localparam int      RANDOM_GOAL = 600;
  localparam int      QUIET_LIMIT = 4000;
  localparam int      HOLD_CYCLES = 600;
  localparam int      DRAIN_WAIT  = 300;
  localparam op_t     OP_SPARE    = 3'd7;
  localparam word_t   WORD_MIN    = 32'sh8000_0000;
  localparam word_t   WORD_MAX    = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    TR_FLAT, TR_SEND_GAPS, TR_RECV_GAPS, TR_BOTH_GAPS
  } traffic_t;

  typedef struct packed {
    op_t   op;
    pos_t  position;
    word_t word_in;
  } request_t;

  typedef struct packed {
    status_t status;
    word_t   word_out;
    hit_t    hit_index;
    ent_t    entries;
  } reply_t;

  logic clk;
  logic rst_n;

  ils_in_if  in_ch ();
  ils_out_if out_ch ();

  indexed_list_store #(.CAPACITY(CAPACITY)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  request_t request_q[$];
  reply_t   awaited_replies[$];
  int       total_items;
  int       gen_len;
  int       accepted_cnt;
  int       replies_seen;
  int       mismatches;
  int       hold_left;
  bit       hold_done;
  int       quiet_cycles;

  word_t    list_mem [CAPACITY];
  int       list_len;
  int       op_tally [8];
  int       peak_len;
  int       full_rejects;
  int       range_rejects;
  int       search_hits;

  function automatic reply_t list_apply(request_t rq);
    reply_t rp;
    int     i;
    int     lo;
    int     hi;
    int     mid;
    rp = '{status: ST_OK, word_out: '0, hit_index: '0, entries: '0};
    op_tally[rq.op]++;
    case (rq.op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          rp.status = ST_FULL;
        end else begin
          list_mem[list_len] = rq.word_in;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (rq.position > list_len) begin
          rp.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          rp.status = ST_FULL;
        end else begin
          for (i = list_len; i > rq.position; i--) list_mem[i] = list_mem[i - 1];
          list_mem[rq.position] = rq.word_in;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (rq.position >= list_len) begin
          rp.status = ST_RANGE;
        end else begin
          rp.word_out = list_mem[rq.position];
          for (i = rq.position; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      OP_GET: begin
        if (rq.position >= list_len) rp.status = ST_RANGE;
        else rp.word_out = list_mem[rq.position];
      end
      OP_SET: begin
        if (rq.position >= list_len) begin
          rp.status = ST_RANGE;
        end else begin
          rp.word_out = list_mem[rq.position];
          list_mem[rq.position] = rq.word_in;
        end
      end
      OP_SEARCH: begin
        lo = 0;
        hi = list_len;
        rp.hit_index = HIT_NONE;
        while (lo < hi) begin
          mid = lo + (hi - 1 - lo) / 2;
          if (list_mem[mid] == rq.word_in) begin
            rp.hit_index = hit_t'(mid);
            search_hits++;
            break;
          end else if (list_mem[mid] < rq.word_in) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    if (rp.status == ST_FULL) full_rejects++;
    if (rp.status == ST_RANGE) range_rejects++;
    if (list_len > peak_len) peak_len = list_len;
    rp.entries = ent_t'(list_len);
    return rp;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH result %0d %s: expected %0h, got %0h", replies_seen, what, want, got);
    mismatches++;
  endtask

  function automatic traffic_t traffic_mode();
    return traffic_t'((accepted_cnt / 64) % 4);
  endfunction

  function automatic bit send_gap();
    case (traffic_mode())
      TR_SEND_GAPS: return $urandom_range(0, 99) < 52;
      TR_BOTH_GAPS: return $urandom_range(0, 99) < 29;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (traffic_mode())
      TR_RECV_GAPS: return $urandom_range(0, 99) < 52;
      TR_BOTH_GAPS: return $urandom_range(0, 99) < 29;
      default:      return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    request_t nxt;
    request_t seen;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.op       = in_ch.op;
        seen.position = in_ch.position;
        seen.word_in  = in_ch.word_in;
        awaited_replies.push_back(list_apply(seen));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() > 0 && !send_gap()) begin
          nxt = request_q.pop_front();
          in_ch.op       <= nxt.op;
          in_ch.position <= nxt.position;
          in_ch.word_in  <= nxt.word_in;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        replies_seen <= replies_seen + 1;
        if (awaited_replies.size() == 0) begin
          report("arrived with nothing awaited", '0, out_ch.word_out);
        end else begin
          want = awaited_replies.pop_front();
          if (out_ch.status !== want.status)
            report("status", 32'(want.status), 32'(out_ch.status));
          if (out_ch.word_out !== want.word_out)
            report("word_out", want.word_out, out_ch.word_out);
          if (out_ch.hit_index !== want.hit_index)
            report("hit_index", 32'(want.hit_index), 32'(out_ch.hit_index));
          if (out_ch.entries !== want.entries)
            report("entries", 32'(want.entries), 32'(out_ch.entries));
        end
      end
      out_ch.ready <= (hold_left == 0) && !recv_stall();
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d of %0d results seen",
               quiet_cycles, replies_seen, total_items);
      $display("FAIL indexed_list_store");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic queue_req(op_t op, int pos, word_t w);
    request_t rq;
    rq.op       = op;
    rq.position = pos_t'(pos);
    rq.word_in  = w;
    case (op)
      OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_INSERT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
      OP_REMOVE: if (pos < gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
    request_q.push_back(rq);
  endtask

  task automatic mixed_burst(int n);
    int  k;
    int  r;
    int  pos;
    op_t op;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 25)      op = OP_APPEND;
      else if (r < 45) op = OP_INSERT;
      else if (r < 62) op = OP_REMOVE;
      else if (r < 74) op = OP_GET;
      else if (r < 85) op = OP_SET;
      else if (r < 94) op = OP_SEARCH;
      else if (r < 98) op = OP_CLEAR;
      else             op = OP_SPARE;
      if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, gen_len);
      else pos = $urandom_range(0, 511);
      queue_req(op, pos, pick_word());
    end
  endtask

  task automatic sorted_burst();
    word_t keys[$];
    word_t v;
    word_t key;
    int    n;
    int    k;
    int    r;
    queue_req(OP_CLEAR, $urandom_range(0, 511), pick_word());
    n = $urandom_range(0, 24);
    v = word_t'($urandom) >>> 1;
    for (k = 0; k < n; k++) begin
      v = v + word_t'($urandom_range(0, 3));
      keys.push_back(v);
      queue_req(OP_APPEND, $urandom_range(0, 511), v);
    end
    for (k = $urandom_range(3, 10); k > 0; k--) begin
      r = $urandom_range(0, 99);
      if (keys.size() > 0 && r < 60) key = keys[$urandom_range(0, keys.size() - 1)];
      else if (keys.size() > 0 && r < 80) key = keys[$urandom_range(0, keys.size() - 1)] + 1;
      else key = pick_word();
      queue_req(OP_SEARCH, $urandom_range(0, 511), key);
    end
  endtask

  task automatic fill_to_capacity();
    queue_req(OP_CLEAR, 0, '0);
    while (gen_len < CAPACITY) queue_req(OP_APPEND, $urandom_range(0, 511), pick_word());
    queue_req(OP_APPEND, 0, WORD_MAX);
    queue_req(OP_INSERT, CAPACITY + 1, WORD_MIN);
    queue_req(OP_INSERT, CAPACITY, WORD_MIN);
    queue_req(OP_INSERT, 0, WORD_MIN);
    queue_req(OP_GET, CAPACITY - 1, '0);
    queue_req(OP_SET, CAPACITY - 1, WORD_MIN);
    queue_req(OP_SEARCH, 0, pick_word());
    queue_req(OP_REMOVE, 0, '0);
    queue_req(OP_INSERT, 0, WORD_MAX);
    queue_req(OP_REMOVE, CAPACITY - 1, '0);
    queue_req(OP_GET, CAPACITY, '0);
    queue_req(OP_CLEAR, 0, '0);
  endtask

  initial begin
    bit filled;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_APPEND;
    in_ch.position = '0;
    in_ch.word_in  = '0;
    out_ch.ready   = 1'b0;
    gen_len        = 0;
    accepted_cnt   = 0;
    replies_seen   = 0;
    mismatches     = 0;
    list_len       = 0;
    peak_len       = 0;
    full_rejects   = 0;
    range_rejects  = 0;
    search_hits    = 0;
    foreach (op_tally[j]) op_tally[j] = 0;
    filled         = 1'b0;

    // empty list rejects and searches
    queue_req(OP_GET, 0, '0);
    queue_req(OP_REMOVE, 0, '0);
    queue_req(OP_SET, 0, WORD_MAX);
    queue_req(OP_SEARCH, 0, 32'sd5);
    queue_req(OP_INSERT, 1, 32'sd7);
    queue_req(OP_SPARE, 511, -1);
    // build, overwrite, search with duplicates, shrink
    queue_req(OP_INSERT, 0, WORD_MIN);
    queue_req(OP_APPEND, 0, WORD_MAX);
    queue_req(OP_INSERT, 1, '0);
    queue_req(OP_INSERT, 3, -1);
    queue_req(OP_SET, 3, WORD_MAX);
    queue_req(OP_SEARCH, 0, WORD_MAX);
    queue_req(OP_SEARCH, 0, WORD_MIN);
    queue_req(OP_SEARCH, 0, 32'sd1);
    queue_req(OP_GET, 256, '0);
    queue_req(OP_REMOVE, 3, '0);
    queue_req(OP_REMOVE, 0, '0);
    queue_req(OP_GET, 1, '0);
    queue_req(OP_SET, 4, '0);
    queue_req(OP_REMOVE, 2, '0);
    queue_req(OP_CLEAR, 0, '0);
    queue_req(OP_GET, 0, '0);
    queue_req(OP_APPEND, 0, 32'sh5555_5555);
    queue_req(OP_SEARCH, 0, 32'sh5555_5555);

    while (request_q.size() < RANDOM_GOAL) begin
      if (!filled && request_q.size() >= 150) begin
        fill_to_capacity();
        filled = 1'b1;
      end else if ($urandom_range(0, 99) < 60) begin
        mixed_burst($urandom_range(10, 30));
      end else begin
        sorted_burst();
      end
    end
    total_items = request_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (replies_seen < total_items) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (awaited_replies.size() != 0)
      report("results never delivered", '0, awaited_replies.size());

    $display("covered %0d requests: append %0d insert %0d remove %0d get %0d set %0d",
             total_items, op_tally[OP_APPEND], op_tally[OP_INSERT], op_tally[OP_REMOVE],
             op_tally[OP_GET], op_tally[OP_SET]);
    $display("search %0d (hits %0d) clear %0d spare %0d; peak %0d entries, %0d full, %0d range",
             op_tally[OP_SEARCH], search_hits, op_tally[OP_CLEAR], op_tally[OP_SPARE],
             peak_len, full_rejects, range_rejects);
    if (mismatches == 0) begin
      $display("PASS indexed_list_store");
    end else begin
      $display("FAIL indexed_list_store");
    end
    $finish;
  end

endmodule
